// ===== design/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define PTS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ===== design/pts_pkg.sv =====
// Shared types and constants of the periodic priority task scheduler.
// No dependencies; used by pts_front, pts_engine and the top level.
`default_nettype none

package pts_pkg;

  localparam int CMD_W         = 2;
  localparam int ID_W          = 8;
  localparam int PER_W         = 16;
  localparam int PRI_W         = 16;
  localparam int TICK_W        = 16;
  localparam int MAX_TASKS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [ID_W-1:0]  task_id;
    logic [PER_W-1:0] period;
    logic [PRI_W-1:0] priority_req;
  } cmd_item_t;

  typedef struct packed {
    logic            status;
    logic            dispatched;
    logic [ID_W-1:0] run_id;
    logic            last;
  } result_t;

endpackage

`default_nettype wire

// ===== design/periodic_priority_task_scheduler_top.sv =====
// Create, delete and tick pass through the front queue and then the result register; a run
// passes through the queue, the scan's pend register and the result register before its
// first dispatch, then gives one result per cycle while the output accepts. One non-run item
// per cycle likewise; a run scan of up to 8 dispatches holds the back end from new items.
// Reset: synchronous, active low; clears queue, control state and every tick counter.
// Top level: joins pts_front and pts_engine; depends on pts_pkg and assert_macros.svh.
`default_nettype none

module periodic_priority_task_scheduler_top #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // [1:0] command, [9:2] task_id, [25:10] period, [41:26] priority_req, rest zero
  input  wire  [pts_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [0] status, [8:1] run_id, rest zero
  output logic [pts_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] dispatched
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import pts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic             q_valid, q_pop;
  cmd_item_t        q_item;
  result_t          res;
  logic [CNT_W-1:0] task_count;

  pts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (in_tdata),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pts_engine #(
    .MAX_TASKS (MAX_TASKS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready),
    .task_count (task_count)
  );

  assign out_tdata = {(OUT_TDATA_W - ID_W - 1)'(0), res.run_id, res.status};
  assign out_tuser = res.dispatched;
  assign out_tlast = res.last;

`include "assert_macros.svh"

  `PTS_ASSERT(a_plain_result_form, out_tvalid && !out_tuser |-> out_tlast && out_tdata[8:1] == 8'd0, "non-dispatch result must be last with zero id")
  `PTS_ASSERT(a_dispatch_succeeds, out_tvalid && out_tuser |-> !out_tdata[0], "dispatch result flagged as failed")
  `PTS_ASSERT_NEVER(a_count_bound, task_count > CNT_W'(MAX_TASKS), "task count beyond table size")

endmodule

`default_nettype wire

// ===== design/pts_front.sv =====
// Front end: accepts command items, decodes them and holds them in a short queue.
// Depends on pts_pkg.
`default_nettype none

module pts_front (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            s_valid,
  output logic                           s_ready,
  input  wire  [pts_pkg::IN_TDATA_W-1:0] s_data,
  output logic                           q_valid,
  output pts_pkg::cmd_item_t             q_item,
  input  wire                            q_pop
);
  import pts_pkg::*;

  localparam int QD  = QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);
  localparam int QLW = $clog2(QD + 1);

  cmd_item_t      mem_r [QD];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLW-1:0] lvl_r, lvl_nxt;
  cmd_item_t      item_in;
  logic           push;

  // field unpack, command first in the low bits
  always_comb begin
    item_in.cmd          = cmd_t'(s_data[CMD_W-1:0]);
    item_in.task_id      = s_data[CMD_W +: ID_W];
    item_in.period       = s_data[CMD_W+ID_W +: PER_W];
    item_in.priority_req = s_data[CMD_W+ID_W+PER_W +: PRI_W];
  end

  assign s_ready = (lvl_r != QLW'(QD));
  assign push    = s_valid && s_ready;
  assign q_valid = (lvl_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    lvl_nxt    = lvl_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + QAW'(1);
    end
    if (push && !q_pop) begin
      lvl_nxt = lvl_r + QLW'(1);
    end else if (!push && q_pop) begin
      lvl_nxt = lvl_r - QLW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/pts_engine.sv =====
// Back end: task table, command execution and dispatch scan with an output register.
// Depends on pts_pkg.
`default_nettype none

module pts_engine #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                q_valid,
  input  pts_pkg::cmd_item_t                 q_item,
  output logic                               q_pop,
  output logic                               res_valid,
  output pts_pkg::result_t                   res,
  input  wire                                res_ready,
  output logic [$clog2(MAX_TASKS+1)-1:0]     task_count
);
  import pts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int RC_W  = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_TASKS-1:0] pend_r, pend_nxt;
  logic [RC_W-1:0]      rcnt_r, rcnt_nxt;
  logic                 res_valid_r, res_valid_nxt;
  result_t              res_r, res_nxt;

  logic [ID_W-1:0]   id_r   [MAX_TASKS];
  logic [PER_W-1:0]  per_r  [MAX_TASKS];
  logic [PRI_W-1:0]  pri_r  [MAX_TASKS];
  logic [TICK_W-1:0] ticks_r[MAX_TASKS];

  logic [MAX_TASKS-1:0] gt_mask, match, due, sel, rest;
  logic [ID_W-1:0]      sel_id;
  logic                 full, found, out_ok, run_last;
  logic                 do_create, do_delete, do_tick, do_emit;

  assign out_ok     = !res_valid_r || res_ready;
  assign full       = (count_r == CNT_W'(MAX_TASKS));
  assign found      = |match;
  // lowest pending due entry, in table order
  assign sel        = pend_r & (~pend_r + MAX_TASKS'(1));
  assign rest       = pend_r & ~sel;
  assign run_last   = (rest == '0) || (rcnt_r == RC_W'(MAX_RESULTS - 1));
  assign res_valid  = res_valid_r;
  assign res        = res_r;
  assign task_count = count_r;

  always_comb begin
    sel_id = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      sel_id = sel_id | (id_r[i] & {ID_W{sel[i]}});
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    rcnt_nxt      = rcnt_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    do_create     = 1'b0;
    do_delete     = 1'b0;
    do_tick       = 1'b0;
    do_emit       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && out_ok) begin
          q_pop              = 1'b1;
          res_nxt.status     = 1'b0;
          res_nxt.dispatched = 1'b0;
          res_nxt.run_id     = '0;
          res_nxt.last       = 1'b1;
          unique case (q_item.cmd)
            CMD_CREATE: begin
              do_create      = 1'b1;
              res_valid_nxt  = 1'b1;
              res_nxt.status = full;
              if (!full) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              do_delete      = 1'b1;
              res_valid_nxt  = 1'b1;
              res_nxt.status = !found;
              if (found) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_TICK: begin
              do_tick       = 1'b1;
              res_valid_nxt = 1'b1;
            end
            CMD_RUN: begin
              if (due == '0) begin
                res_valid_nxt = 1'b1;
              end else begin
                pend_nxt  = due;
                rcnt_nxt  = '0;
                state_nxt = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (out_ok) begin
          do_emit            = 1'b1;
          res_valid_nxt      = 1'b1;
          res_nxt.status     = 1'b0;
          res_nxt.dispatched = 1'b1;
          res_nxt.run_id     = sel_id;
          res_nxt.last       = run_last;
          pend_nxt           = rest;
          rcnt_nxt           = rcnt_r + RC_W'(1);
          if (run_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    rcnt_r <= rcnt_nxt;
    res_r  <= res_nxt;
  end

  // one slot of the table per iteration; each takes shifted entries only from its own neighbors
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_slot
    logic              live, prev_gt, ld_new, sh_up, sh_dn, clr_vac, inc, clr_run;
    logic [ID_W-1:0]   prev_id,  next_id;
    logic [PER_W-1:0]  prev_per, next_per;
    logic [PRI_W-1:0]  prev_pri, next_pri;
    logic [TICK_W-1:0] prev_tk,  next_tk;

    assign live       = (CNT_W'(g) < count_r);
    assign gt_mask[g] = live && (pri_r[g] > q_item.priority_req);
    assign match[g]   = live && (id_r[g] == q_item.task_id);
    assign due[g]     = live && (ticks_r[g] == per_r[g]);

    if (g == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_id  = '0;
      assign prev_per = '0;
      assign prev_pri = '0;
      assign prev_tk  = '0;
    end else begin : g_prev
      assign prev_gt  = gt_mask[g-1];
      assign prev_id  = id_r[g-1];
      assign prev_per = per_r[g-1];
      assign prev_pri = pri_r[g-1];
      assign prev_tk  = ticks_r[g-1];
    end

    if (g == MAX_TASKS - 1) begin : g_lastslot
      assign next_id  = '0;
      assign next_per = '0;
      assign next_pri = '0;
      assign next_tk  = '0;
    end else begin : g_next
      assign next_id  = id_r[g+1];
      assign next_per = per_r[g+1];
      assign next_pri = pri_r[g+1];
      assign next_tk  = ticks_r[g+1];
    end

    // insert point: first slot whose priority is strictly greater, else the end
    assign ld_new  = do_create && !full && (CNT_W'(g) <= count_r) && !prev_gt &&
                     (gt_mask[g] || (CNT_W'(g) == count_r));
    assign sh_up   = do_create && !full && (CNT_W'(g) <= count_r) && prev_gt;
    // slots from the first match up to count-2 pull from above
    assign sh_dn   = do_delete && (|match[g:0]) && (CNT_W'(g + 1) < count_r);
    assign clr_vac = do_delete && found && (CNT_W'(g + 1) == count_r);
    assign inc     = do_tick && live && (ticks_r[g] != {TICK_W{1'b1}});
    assign clr_run = do_emit && sel[g];

    always_ff @(posedge clk) begin
      if (ld_new) begin
        id_r[g]  <= q_item.task_id;
        per_r[g] <= q_item.period;
        pri_r[g] <= q_item.priority_req;
      end else if (sh_up) begin
        id_r[g]  <= prev_id;
        per_r[g] <= prev_per;
        pri_r[g] <= prev_pri;
      end else if (sh_dn) begin
        id_r[g]  <= next_id;
        per_r[g] <= next_per;
        pri_r[g] <= next_pri;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ticks_r[g] <= '0;
      end else if (ld_new || clr_vac || clr_run) begin
        ticks_r[g] <= '0;
      end else if (sh_up) begin
        ticks_r[g] <= prev_tk;
      end else if (sh_dn) begin
        ticks_r[g] <= next_tk;
      end else if (inc) begin
        ticks_r[g] <= ticks_r[g] + TICK_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
